// File: hdl/ffha_pkg.sv
// ffha_pkg: shared types and codes of the first-fit heap allocator.
// No dependencies; used by first_fit_heap_allocator_unit and its checker.
`timescale 1ns / 1ps

package ffha_pkg;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_CHK,
    S_WBLK,
    S_WPAR,
    S_FREE_LINK,
    S_FREE_TAIL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

endpackage

// File: hdl/first_fit_heap_allocator_unit.sv
// Channel   | Direction | Beat contents
// in_       | input     | in_req_type, in_request_size, in_user_offset
// out_      | output    | out_status, out_granted_offset
//
// An allocate walks the free list with one header memory read and one fit
// test per visited node, then writes the split block (if it splits), relinks
// the parent and reports. A free appends the block at the tail and reports;
// an ignored free only reports. Items are handled one at a time; a new beat
// is taken while the previous result still waits on out_ready.
// After reset a clearing pass over every header memory entry initialises the
// header memories, during which in_ready stays low.
// Depends on ffha_pkg.
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [11:0] in_request_size,
  input  logic [11:0] in_user_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [11:0] out_granted_offset
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int PW = $clog2(HEAP_BYTES + 1);
  localparam int CW = $clog2(2 * HEAP_BYTES + 4096 + 2 * HEADER_BYTES);
  localparam logic [PW-1:0] NULL_P = PW'(HEAP_BYTES);
  localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);
  localparam logic [AW-1:0] LAST_A = AW'(HEAP_BYTES - 1);

  logic [PW-1:0] size_mem [HEAP_BYTES];
  logic [PW-1:0] link_mem [HEAP_BYTES];

  ffha_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [PW-1:0] parent_r, parent_nxt;
  logic [PW-1:0] steps_r, steps_nxt;
  logic [11:0]   req_r, req_nxt;
  logic [CW-1:0] reqh_r, reqh_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic          exact_r, exact_nxt;
  logic          split_r, split_nxt;
  logic [PW-1:0] blk_r, blk_nxt;
  logic [PW-1:0] nlink_r, nlink_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [11:0]   res_off_r, res_off_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [11:0]   out_off_r, out_off_nxt;

  logic [PW-1:0] size_q_r;
  logic [PW-1:0] link_q_r;

  logic          size_we;
  logic [AW-1:0] size_wa;
  logic [PW-1:0] size_wd;
  logic          link_we;
  logic [AW-1:0] link_wa;
  logic [PW-1:0] link_wd;

  logic [CW-1:0] size_c;
  logic [CW-1:0] blk_sum;
  logic [CW-1:0] uoff_c;
  logic [CW-1:0] hdr_c;
  logic [CW-1:0] grant_c;
  logic          next_null;
  logic          fit_exact;
  logic          fit_split;
  logic [PW-1:0] target;

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_wa] <= size_wd;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    size_q_r <= size_mem[ptr_r[AW-1:0]];
    link_q_r <= link_mem[ptr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffha_pkg::S_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    parent_r     <= parent_nxt;
    steps_r      <= steps_nxt;
    req_r        <= req_nxt;
    reqh_r       <= reqh_nxt;
    exact_r      <= exact_nxt;
    split_r      <= split_nxt;
    blk_r        <= blk_nxt;
    nlink_r      <= nlink_nxt;
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
  end

  assign size_c    = CW'(size_q_r);
  assign blk_sum   = CW'(ptr_r) + reqh_r;
  assign uoff_c    = CW'(in_user_offset);
  assign hdr_c     = uoff_c - HDR_C;
  assign grant_c   = CW'(ptr_r) + HDR_C;
  assign next_null = (link_q_r >= NULL_P);
  assign fit_exact = (size_c == CW'(req_r));
  assign fit_split = (size_c > reqh_r) && (blk_sum < HEAP_C);
  assign target    = exact_r ? nlink_r : blk_r;

  assign in_ready           = (state_r == ffha_pkg::S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_offset = out_off_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    ptr_nxt        = ptr_r;
    parent_nxt     = parent_r;
    steps_nxt      = steps_r;
    req_nxt        = req_r;
    reqh_nxt       = reqh_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    exact_nxt      = exact_r;
    split_nxt      = split_r;
    blk_nxt        = blk_r;
    nlink_nxt      = nlink_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    size_we        = 1'b0;
    size_wa        = ptr_r[AW-1:0];
    size_wd        = '0;
    link_we        = 1'b0;
    link_wa        = ptr_r[AW-1:0];
    link_wd        = '0;

    unique case (state_r)
      ffha_pkg::S_CLEAR: begin
        size_we = 1'b1;
        link_we = 1'b1;
        size_wa = clr_r;
        link_wa = clr_r;
        if (clr_r == '0) begin
          size_wd = PW'(HEAP_BYTES - HEADER_BYTES);
          link_wd = NULL_P;
        end
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_A) begin
          state_nxt = ffha_pkg::S_IDLE;
        end
      end

      ffha_pkg::S_IDLE: begin
        if (in_valid) begin
          res_off_nxt = '0;
          if (in_req_type == ffha_pkg::REQ_ALLOC) begin
            req_nxt    = in_request_size;
            reqh_nxt   = CW'(in_request_size) + HDR_C;
            ptr_nxt    = head_r;
            parent_nxt = NULL_P;
            steps_nxt  = '0;
            if (head_r >= NULL_P) begin
              res_status_nxt = ffha_pkg::ST_NO_FIT;
              state_nxt      = ffha_pkg::S_DONE;
            end else begin
              state_nxt = ffha_pkg::S_RD;
            end
          end else if (uoff_c < HDR_C || uoff_c == '0 || hdr_c >= HEAP_C) begin
            res_status_nxt = ffha_pkg::ST_IGNORED;
            state_nxt      = ffha_pkg::S_DONE;
          end else begin
            ptr_nxt   = hdr_c[PW-1:0];
            state_nxt = ffha_pkg::S_FREE_LINK;
          end
        end
      end

      ffha_pkg::S_RD: begin
        state_nxt = ffha_pkg::S_CHK;
      end

      ffha_pkg::S_CHK: begin
        exact_nxt = fit_exact;
        split_nxt = !fit_exact && fit_split;
        blk_nxt   = blk_sum[PW-1:0];
        nlink_nxt = next_null ? NULL_P : link_q_r;
        if (steps_r == NULL_P || next_null || fit_exact || fit_split) begin
          if (fit_exact) begin
            state_nxt = ffha_pkg::S_WPAR;
          end else if (fit_split) begin
            state_nxt = ffha_pkg::S_WBLK;
          end else begin
            res_status_nxt = ffha_pkg::ST_NO_FIT;
            state_nxt      = ffha_pkg::S_DONE;
          end
        end else begin
          parent_nxt = ptr_r;
          ptr_nxt    = link_q_r;
          steps_nxt  = steps_r + PW'(1);
          state_nxt  = ffha_pkg::S_RD;
        end
      end

      ffha_pkg::S_WBLK: begin
        size_we   = 1'b1;
        size_wa   = blk_r[AW-1:0];
        size_wd   = PW'(size_c - reqh_r);
        link_we   = 1'b1;
        link_wa   = blk_r[AW-1:0];
        link_wd   = nlink_r;
        state_nxt = ffha_pkg::S_WPAR;
      end

      ffha_pkg::S_WPAR: begin
        if (parent_r >= NULL_P) begin
          head_nxt = target;
        end else begin
          link_we = 1'b1;
          link_wa = parent_r[AW-1:0];
          link_wd = target;
        end
        if (split_r) begin
          size_we = 1'b1;
          size_wa = ptr_r[AW-1:0];
          size_wd = PW'(req_r);
        end
        if (ptr_r == tail_r) begin
          tail_nxt = exact_r ? parent_r : blk_r;
        end
        res_status_nxt = ffha_pkg::ST_OK;
        res_off_nxt    = grant_c[11:0];
        state_nxt      = ffha_pkg::S_DONE;
      end

      ffha_pkg::S_FREE_LINK: begin
        link_we   = 1'b1;
        link_wd   = NULL_P;
        state_nxt = ffha_pkg::S_FREE_TAIL;
      end

      ffha_pkg::S_FREE_TAIL: begin
        if (head_r >= NULL_P) begin
          head_nxt = ptr_r;
        end else if (tail_r >= NULL_P) begin
          link_we = 1'b1;
          link_wa = head_r[AW-1:0];
          link_wd = ptr_r;
        end else begin
          link_we = 1'b1;
          link_wa = tail_r[AW-1:0];
          link_wd = ptr_r;
        end
        tail_nxt       = ptr_r;
        res_status_nxt = ffha_pkg::ST_OK;
        state_nxt      = ffha_pkg::S_DONE;
      end

      ffha_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_off_nxt    = res_off_r;
          state_nxt      = ffha_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ffha_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/ffha_checker.sv
// ffha_checker: port-level assertions for first_fit_heap_allocator_unit.
// Depends on ffha_pkg; bound into first_fit_heap_allocator_unit at the end of this file.
`timescale 1ns / 1ps

module ffha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [11:0] out_granted_offset
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result beat dropped before it was taken.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input taken again while a request is in progress.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != ffha_pkg::ST_UNUSED)
    else $error("Result carries an undefined status code.");

  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffha_pkg::ST_OK |-> out_granted_offset == 12'd0)
    else $error("Failed or ignored request returned a non-zero offset.");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("Input accepted before the header memories were cleared.");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_granted_offset (out_granted_offset)
);
